// ----- design/u8sd_pkg.sv -----
package u8sd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CP_W        = 21;
  localparam int unsigned ERR_W       = 3;
  localparam int unsigned PAY_W       = 7;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_class_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 3'd0,
    ERR_LEAD  = 3'd1,
    ERR_CONT  = 3'd2,
    ERR_TRUNC = 3'd3,
    ERR_ZERO  = 3'd4
  } err_kind_e;

  // one classified byte on its way from front to back
  typedef struct packed {
    byte_class_e      cls;
    logic [PAY_W-1:0] payload;
    logic             eot;
  } entry_t;

endpackage

// ----- design/u8sd_front.sv -----
module u8sd_front (
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,  // text_byte
  input  logic              s_axis_tlast_i,  // end_of_text
  input  logic              q_full_i,
  output logic              q_push_o,
  output u8sd_pkg::entry_t  q_entry_o
);
  import u8sd_pkg::*;

  logic [7:0] b;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // class and payload bits by the prefix of the byte
  always_comb begin
    q_entry_o.eot = s_axis_tlast_i;
    if (b[7] == 1'b0) begin
      q_entry_o.cls     = CLS_ASCII;
      q_entry_o.payload = b[6:0];
    end else if (b[7:6] == 2'b10) begin
      q_entry_o.cls     = CLS_CONT;
      q_entry_o.payload = {1'b0, b[5:0]};
    end else if (b[7:5] == 3'b110) begin
      q_entry_o.cls     = CLS_LEAD2;
      q_entry_o.payload = {2'b00, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      q_entry_o.cls     = CLS_LEAD3;
      q_entry_o.payload = {3'b000, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      q_entry_o.cls     = CLS_LEAD4;
      q_entry_o.payload = {4'b0000, b[2:0]};
    end else begin
      q_entry_o.cls     = CLS_BAD;
      q_entry_o.payload = '0;
    end
  end

endmodule

// ----- design/u8sd_queue.sv -----
module u8sd_queue #(
  parameter int unsigned Depth = u8sd_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8sd_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output u8sd_pkg::entry_t  entry_o
);
  import u8sd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- design/u8sd_back.sv -----
module u8sd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  u8sd_pkg::entry_t  q_entry_i,
  output logic              q_pop_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [23:0]       m_axis_tdata_o,  // code_point [20:0], zero fill [23:21]
  output logic [2:0]        m_axis_tuser_o,  // error_kind [2:0]
  output logic              m_axis_tlast_o   // last
);
  import u8sd_pkg::*;

  logic [1:0]       bytes_left_q, bytes_left_d;
  logic [CP_W-1:0]  partial_q, partial_d;
  logic             failed_q, failed_d;
  err_kind_e        err_q, err_d;

  logic             out_valid_q, out_valid_d;
  logic [CP_W-1:0]  out_cp_q;
  err_kind_e        out_err_q;
  logic             out_last_q;

  logic             done;
  logic             emit;
  logic [CP_W-1:0]  value;
  logic [CP_W-1:0]  shifted;
  logic [CP_W-1:0]  emit_cp;
  err_kind_e        emit_err;

  // output register frees when empty or taken this cycle
  assign q_pop_o = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign shifted = {partial_q[CP_W-7:0], q_entry_i.payload[5:0]};

  always_comb begin
    bytes_left_d = bytes_left_q;
    partial_d    = partial_q;
    failed_d     = failed_q;
    err_d        = err_q;
    done         = 1'b0;
    value        = '0;

    if (!failed_q) begin
      if (bytes_left_q == 2'd0) begin
        unique case (q_entry_i.cls)
          CLS_ASCII: begin
            value = CP_W'(q_entry_i.payload);
            done  = 1'b1;
          end
          CLS_LEAD2: begin
            partial_d    = CP_W'(q_entry_i.payload);
            bytes_left_d = 2'd1;
          end
          CLS_LEAD3: begin
            partial_d    = CP_W'(q_entry_i.payload);
            bytes_left_d = 2'd2;
          end
          CLS_LEAD4: begin
            partial_d    = CP_W'(q_entry_i.payload);
            bytes_left_d = 2'd3;
          end
          default: begin
            failed_d = 1'b1;
            err_d    = ERR_LEAD;
          end
        endcase
      end else if (q_entry_i.cls != CLS_CONT) begin
        failed_d     = 1'b1;
        err_d        = ERR_CONT;
        bytes_left_d = 2'd0;
        partial_d    = '0;
      end else begin
        bytes_left_d = bytes_left_q - 2'd1;
        if (bytes_left_q == 2'd1) begin
          value     = shifted;
          partial_d = '0;
          done      = 1'b1;
        end else begin
          partial_d = shifted;
        end
      end

      if (done && value == '0) begin
        done     = 1'b0;
        failed_d = 1'b1;
        err_d    = ERR_ZERO;
      end

      // sequence still open at the end of the text
      if (!failed_d && q_entry_i.eot && bytes_left_d != 2'd0) begin
        failed_d     = 1'b1;
        err_d        = ERR_TRUNC;
        bytes_left_d = 2'd0;
        partial_d    = '0;
      end
    end

    emit     = done || q_entry_i.eot;
    emit_cp  = failed_d ? '0 : value;
    emit_err = failed_d ? err_d : ERR_NONE;

    if (q_entry_i.eot) begin
      bytes_left_d = 2'd0;
      partial_d    = '0;
      failed_d     = 1'b0;
      err_d        = ERR_NONE;
    end
  end

  always_comb begin
    if (q_pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 2'd0;
      partial_q    <= '0;
      failed_q     <= 1'b0;
      err_q        <= ERR_NONE;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        bytes_left_q <= bytes_left_d;
        partial_q    <= partial_d;
        failed_q     <= failed_d;
        err_q        <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_cp_q   <= emit_cp;
      out_err_q  <= emit_err;
      out_last_q <= q_entry_i.eot;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_cp_q};
  assign m_axis_tuser_o  = out_err_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- design/utf8_stream_decoder_unit.sv -----
// UTF-8 decoder for a byte stream: each byte enters with tlast marking the final byte of a
// text, and each completed 1 to 4 byte sequence leaves as one 21-bit code point. The first
// error in a text (bad lead, bad continuation, truncated sequence, zero value) fails the
// whole text; later bytes are dropped and the final byte yields one transaction with tlast
// that carries the error kind on tuser and a zero code point. Sustained rate is one byte per
// clock while m_axis_tready is high, set by the back stage's sequence state update; a result
// passes through the queue memory and then the output register when the path is clear, and a
// queue of QueueDepth classified bytes lets the input keep streaming while the output is stalled.
module utf8_stream_decoder_unit #(
  parameter int unsigned QueueDepth = u8sd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte [7:0]
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // code_point [20:0], zero fill [23:21]
  output logic [2:0]  m_axis_tuser_o,   // error_kind [2:0]
  output logic        m_axis_tlast_o    // last
);
  import u8sd_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t q_in;
  entry_t q_out;

  u8sd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_in)
  );

  u8sd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  u8sd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_out),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
